// ===== hw/rtl/vdp_host_port_interface_assert.svh =====
// assertion macros for the vdp host port
`ifndef VDP_HOST_PORT_INTERFACE_ASSERT_SVH
`define VDP_HOST_PORT_INTERFACE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define VDPHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define VDPHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VDPHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define VDPHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/vdphp_pkg.sv =====
package vdphp_pkg;

    // video memory geometry
    localparam int VRAM_DEPTH = 16384;
    localparam int ADDR_W     = $clog2(VRAM_DEPTH);
    localparam int HOST_ADDR_W = 14;
    // compare-subtract steps needed to fold a host address into the memory
    localparam int FOLD_STEPS =
        $clog2(((1 << HOST_ADDR_W) + VRAM_DEPTH - 1) / VRAM_DEPTH);

    // control registers
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int REG_MODE  = 1;

    localparam logic [7:0] LAST_ROW = 8'(191);

    // bit positions
    localparam int DISP_EN_BIT    = 6;
    localparam int IRQ_EN_BIT     = 5;
    localparam int CTRL_REG_BIT   = 7;
    localparam int CTRL_NO_PF_BIT = 6;
    localparam int ADDR_HI_W      = 6;

    localparam logic [7:0] STATUS_FRAME = 8'h80;

    typedef enum logic [2:0] {
        FUNC_DATA_WR = 3'd0,
        FUNC_DATA_RD = 3'd1,
        FUNC_CTRL_WR = 3'd2,
        FUNC_STAT_RD = 3'd3,
        FUNC_LINE    = 3'd4
    } t_func;

    typedef struct packed {
        logic       irq_pulse;
        logic [7:0] rdata;
    } t_result;

    // host address modulo memory depth, restoring compare-subtract
    function automatic logic [ADDR_W-1:0] fold_addr(input logic [HOST_ADDR_W-1:0] a);
        logic [HOST_ADDR_W:0] rem;
        rem = {1'b0, a};
        for (int i = FOLD_STEPS - 1; i >= 0; i--) begin
            if (rem >= ((HOST_ADDR_W+1)'(VRAM_DEPTH) << i)) begin
                rem = rem - ((HOST_ADDR_W+1)'(VRAM_DEPTH) << i);
            end
        end
        return rem[ADDR_W-1:0];
    endfunction

    // address plus one, wrapping at the memory depth
    function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] res;
        if (a == ADDR_W'(VRAM_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = a + ADDR_W'(1);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/vdphp_out_buf.sv =====
module vdphp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vdphp_pkg::t_result i_item,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output vdphp_pkg::t_result o_item
);
    import vdphp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !i_ready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !i_ready) begin
                r_skid <= i_item;
            end else begin
                r_out <= i_item;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ===== hw/rtl/vdp_host_port_interface.sv =====
// Host port of a video display processor. Each item on the slave stream is one
// bus access (data write, data read, control write, status read or scanline
// done) and yields exactly one result item on the master stream. The block
// takes one item per clock unless the output buffer is full: every access is
// resolved in the cycle it is accepted, and the video memory read it starts
// lands in the next cycle at the memory output, forwarded to the next item
// if that item needs it. Each result is registered toward the master side; a
// two-entry output buffer (register plus skid) lets the slave side keep taking
// items while one result waits. Throughput is one item per cycle while the
// buffer has room, set by the one-port video memory (one access per item).
// Video memory is not cleared by reset; reading a location never written
// returns whatever it holds. There is no clearing pass.

`include "vdp_host_port_interface_assert.svh"

module vdp_host_port_interface (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // func[2:0], wdata[10:3], row[18:11], zero fill
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // rdata[7:0], irq_pulse[8], zero fill
);
    import vdphp_pkg::*;

    // unpacked input fields
    t_func      func;
    logic [7:0] wdata;
    logic [7:0] row;
    logic       accept;

    assign func   = t_func'(i_s_tdata[2:0]);
    assign wdata  = i_s_tdata[10:3];
    assign row    = i_s_tdata[18:11];
    assign accept = i_s_tvalid && o_s_tready;

    // video memory, single port, registered read
    logic [7:0] r_vram [VRAM_DEPTH];
    logic [7:0] r_mem_q;

    // architectural state
    logic [7:0]        r_ctrl [REG_COUNT];
    logic              r_frame;
    logic [ADDR_W-1:0] r_addr;      // always held already folded into the memory
    logic [7:0]        r_latch;
    logic              r_full;
    logic [7:0]        r_prefetch;
    logic              r_fill;      // memory output holds the new read-ahead byte

    logic              n_frame;
    logic [ADDR_W-1:0] n_addr;
    logic [7:0]        n_latch;
    logic              n_full;
    logic [7:0]        n_prefetch;
    logic              n_fill;

    // memory and register file controls
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic              ctrl_we;
    logic [7:0]        eff_prefetch;
    logic [ADDR_W-1:0] set_at;
    t_result           res;
    logic              buf_full;
    t_result           out_item;

    // folded address for an address-set control pair
    assign set_at = fold_addr({wdata[ADDR_HI_W-1:0], r_latch});

    // read-ahead byte, forwarded straight from the memory while the refill lands
    assign eff_prefetch = r_fill ? r_mem_q : r_prefetch;

    always_comb begin
        n_frame    = r_frame;
        n_addr     = r_addr;
        n_latch    = r_latch;
        n_full     = r_full;
        n_prefetch = eff_prefetch;
        n_fill     = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = r_addr;
        ctrl_we    = 1'b0;
        res        = '0;
        if (accept) begin
            case (func)
                FUNC_DATA_WR: begin
                    // write goes to memory and the read-ahead byte alike
                    mem_we     = 1'b1;
                    n_prefetch = wdata;
                    n_addr     = next_addr(r_addr);
                end
                FUNC_DATA_RD: begin
                    res.rdata = eff_prefetch;
                    mem_re    = 1'b1;
                    n_fill    = 1'b1;
                    n_addr    = next_addr(r_addr);
                end
                FUNC_CTRL_WR: begin
                    if (!r_full) begin
                        n_latch = wdata;
                        n_full  = 1'b1;
                    end else begin
                        if (wdata[CTRL_REG_BIT]) begin
                            ctrl_we = 1'b1;
                        end else if (!wdata[CTRL_NO_PF_BIT]) begin
                            // address set with read-ahead
                            mem_re   = 1'b1;
                            mem_addr = set_at;
                            n_fill   = 1'b1;
                            n_addr   = next_addr(set_at);
                        end else begin
                            n_addr = set_at;
                        end
                        n_full = 1'b0;
                    end
                end
                FUNC_STAT_RD: begin
                    res.rdata = r_frame ? STATUS_FRAME : 8'h00;
                    n_frame   = 1'b0;
                    n_full    = 1'b0;
                end
                FUNC_LINE: begin
                    // frame end only counts while display is on
                    if (r_ctrl[REG_MODE][DISP_EN_BIT] && row == LAST_ROW) begin
                        n_frame       = 1'b1;
                        res.irq_pulse = r_ctrl[REG_MODE][IRQ_EN_BIT];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // memory port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_vram[mem_addr] <= wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_vram[mem_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_ctrl[i] <= 8'h00;
            end
            r_frame    <= 1'b0;
            r_addr     <= '0;
            r_latch    <= 8'h00;
            r_full     <= 1'b0;
            r_prefetch <= 8'h00;
            r_fill     <= 1'b0;
        end else begin
            if (ctrl_we) begin
                r_ctrl[wdata[REG_IDX_W-1:0]] <= r_latch;
            end
            r_frame    <= n_frame;
            r_addr     <= n_addr;
            r_latch    <= n_latch;
            r_full     <= n_full;
            r_prefetch <= n_prefetch;
            r_fill     <= n_fill;
        end
    end

    // result buffer toward the master side
    vdphp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (res),
        .o_full  (buf_full),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_item  (out_item)
    );

    // no item is taken while reset is held
    assign o_s_tready = i_rst_n && !buf_full;
    assign o_m_tdata  = {7'b0, out_item.irq_pulse, out_item.rdata};

    // the slave side only stalls while a result is waiting
    `VDPHP_ASSERT_IMP(a_stall_has_result, i_clk, i_rst_n, !o_s_tready, o_m_tvalid, "stall with no result pending")
    // a refill pending means a memory read was issued the cycle before
    `VDPHP_ASSERT_NXT(a_fill_after_read, i_clk, i_rst_n, !(accept && mem_re), !r_fill, "read-ahead refill without a read")
    // the access address never leaves the memory
    `VDPHP_ASSERT_IMP(a_addr_in_range, i_clk, i_rst_n, 1'b1, {1'b0, r_addr} < (ADDR_W+1)'(VRAM_DEPTH), "access address beyond memory")

endmodule

// ===== dv/vdp_host_port_interface_tb.sv =====
module vdp_host_port_interface_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vdphp_pkg::*;

    // codes 5..7 are not decoded by the port
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    // mode register bits
    localparam logic [7:0] MODE_DISPLAY = 8'(1 << DISP_EN_BIT);
    localparam logic [7:0] MODE_IRQ     = 8'(1 << IRQ_EN_BIT);

    localparam int RANDOM_TARGET = 1975;  // backlog size at which generation stops
    localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake before giving up
    localparam int DRAIN_CYCLES  = 16;    // extra cycles after the last result
    localparam int RESET_CYCLES  = 9;
    localparam int BURST_MAX     = 16;
    localparam int BURST_KEEP    = 32;

    // one bus access as it travels in tdata, func in the low bits
    typedef struct packed {
        logic [7:0] row;
        logic [7:0] wdata;
        logic [2:0] func;
    } t_access;

    // an access waiting to be sent, with the result the port owes for it
    typedef struct packed {
        t_access acc;
        t_result res;
    } t_pending;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // func[2:0], wdata[10:3], row[18:11], zero fill
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // rdata[7:0], irq_pulse[8], zero fill

    vdp_host_port_interface dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shadow of the port state, advanced one access at a time
    // ------------------------------------------------------------------
    logic [7:0]             vram_img [VRAM_DEPTH];
    bit                     vram_set [VRAM_DEPTH];  // entry has been written
    logic [7:0]             ctrl_reg [REG_COUNT];
    bit                     frame_seen;
    logic [HOST_ADDR_W-1:0] host_addr;
    logic [7:0]             pair_byte;
    bit                     pair_half;              // first control byte held
    logic [7:0]             ahead_byte;

    t_pending               access_backlog[$];      // accesses not yet sent
    t_result                due_results[$];         // results owed by the port, oldest first
    logic [HOST_ADDR_W-1:0] stored_base[$];         // recent write bursts, for read-back
    int                     stored_len[$];

    t_result                shown_result;           // result owed for the item on the bus
    t_pending               next_entry;
    t_result                want;
    int                     items_sent;
    int                     item_total;
    int                     fail_count;
    int                     quiet_cycles;

    // host address folded into the memory
    function automatic int unsigned mem_index(input logic [HOST_ADDR_W-1:0] a);
        return int'(a) % VRAM_DEPTH;
    endfunction

    // hand out the read-ahead byte, refill it and step the address
    function automatic logic [7:0] take_ahead();
        logic [7:0]  prior;
        int unsigned at;
        prior      = ahead_byte;
        at         = mem_index(host_addr);
        ahead_byte = vram_img[at];
        host_addr  = HOST_ADDR_W'((at + 1) % VRAM_DEPTH);
        return prior;
    endfunction

    // apply one access to the shadow state, return what the port answers
    function automatic t_result predict_access(input t_access a);
        t_result     r;
        int unsigned at;
        r = '0;
        case (a.func)
            FUNC_DATA_WR: begin
                at           = mem_index(host_addr);
                vram_img[at] = a.wdata;
                vram_set[at] = 1'b1;
                ahead_byte   = a.wdata;
                host_addr    = HOST_ADDR_W'((at + 1) % VRAM_DEPTH);
            end
            FUNC_DATA_RD: begin
                r.rdata = take_ahead();
            end
            FUNC_CTRL_WR: begin
                if (!pair_half) begin
                    pair_byte = a.wdata;
                    pair_half = 1'b1;
                end else begin
                    if (a.wdata[CTRL_REG_BIT]) begin
                        ctrl_reg[a.wdata[REG_IDX_W-1:0]] = pair_byte;
                    end else begin
                        host_addr = {a.wdata[ADDR_HI_W-1:0], pair_byte};
                        if (!a.wdata[CTRL_NO_PF_BIT]) begin
                            void'(take_ahead());
                        end
                    end
                    pair_half = 1'b0;
                end
            end
            FUNC_STAT_RD: begin
                r.rdata    = frame_seen ? STATUS_FRAME : 8'h00;
                frame_seen = 1'b0;
                pair_half  = 1'b0;
            end
            FUNC_LINE: begin
                if (ctrl_reg[REG_MODE][DISP_EN_BIT] && a.row == LAST_ROW) begin
                    frame_seen  = 1'b1;
                    r.irq_pulse = ctrl_reg[REG_MODE][IRQ_EN_BIT];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // would this access pull a never-written memory entry into the read-ahead
    function automatic bit touches_unset(input t_access a);
        if (a.func == FUNC_DATA_RD) begin
            return !vram_set[mem_index(host_addr)];
        end
        if (a.func == FUNC_CTRL_WR && pair_half && !a.wdata[CTRL_REG_BIT]
                && !a.wdata[CTRL_NO_PF_BIT]) begin
            return !vram_set[mem_index({a.wdata[ADDR_HI_W-1:0], pair_byte})];
        end
        return 1'b0;
    endfunction

    // idle share of each side, by how far the run has got
    function automatic int unsigned idle_pct(input bit sender);
        if (items_sent < item_total / 3) begin
            return sender ? 32 : 52;
        end
        if (items_sent < 2 * item_total / 3) begin
            return sender ? 52 : 32;
        end
        return 0;
    endfunction

    // add one access to the backlog; a read of unwritten memory is turned
    // into a write, an address load into one without read-ahead
    task automatic queue_access(input logic [2:0] func, input logic [7:0] wdata,
                                input logic [7:0] row);
        t_pending p;
        p.acc.func  = func;
        p.acc.wdata = wdata;
        p.acc.row   = row;
        if (touches_unset(p.acc)) begin
            if (p.acc.func == FUNC_DATA_RD) begin
                p.acc.func = FUNC_DATA_WR;
            end else begin
                p.acc.wdata[CTRL_NO_PF_BIT] = 1'b1;
            end
        end
        p.res = predict_access(p.acc);
        access_backlog.push_back(p);
    endtask

    // control pair loading the access address, with or without read-ahead
    task automatic set_address(input logic [HOST_ADDR_W-1:0] addr, input bit fetch);
        // a dangling first byte would pair with ours, so drop it first
        if (pair_half) begin
            queue_access(FUNC_STAT_RD, 8'($urandom), 8'($urandom));
        end
        queue_access(FUNC_CTRL_WR, addr[7:0], 8'($urandom));
        queue_access(FUNC_CTRL_WR, {1'b0, !fetch, addr[HOST_ADDR_W-1:8]}, 8'($urandom));
    endtask

    // control pair loading a register; bits 6..3 of the second byte are don't-care
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
        if (pair_half) begin
            queue_access(FUNC_STAT_RD, 8'($urandom), 8'($urandom));
        end
        queue_access(FUNC_CTRL_WR, val, 8'($urandom));
        queue_access(FUNC_CTRL_WR, {1'b1, 4'($urandom), idx}, 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // stimulus generation, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [HOST_ADDR_W-1:0] base;
        logic [7:0]             val;
        int                     len;
        int                     pick;
        int                     n;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;
        items_sent = 0;
        fail_count = 0;
        quiet_cycles = 0;

        // shadow reset
        for (int i = 0; i < VRAM_DEPTH; i++) begin
            vram_set[i] = 1'b0;
            vram_img[i] = 8'h00;
        end
        for (int i = 0; i < REG_COUNT; i++) begin
            ctrl_reg[i] = 8'h00;
        end
        frame_seen = 1'b0;
        host_addr  = '0;
        pair_byte  = 8'h00;
        pair_half  = 1'b0;
        ahead_byte = 8'h00;

        // directed: last row with display off right after reset
        queue_access(FUNC_LINE, 8'h00, LAST_ROW);
        // writes across the top of memory, address wraps to zero
        set_address(HOST_ADDR_W'(VRAM_DEPTH - 2), 1'b0);
        queue_access(FUNC_DATA_WR, 8'h00, 8'h00);
        queue_access(FUNC_DATA_WR, 8'hFF, 8'hFF);
        queue_access(FUNC_DATA_WR, 8'hA5, 8'h5A);
        // reload with read-ahead and read back over the wrap
        set_address(HOST_ADDR_W'(VRAM_DEPTH - 2), 1'b1);
        queue_access(FUNC_DATA_RD, 8'hFF, 8'h00);
        queue_access(FUNC_DATA_RD, 8'h00, 8'hFF);
        // display and interrupt on: row before last does nothing, last row fires
        write_reg(REG_IDX_W'(REG_MODE), MODE_DISPLAY | MODE_IRQ);
        queue_access(FUNC_LINE, 8'h00, LAST_ROW - 8'd1);
        queue_access(FUNC_LINE, 8'hFF, LAST_ROW);
        // status read clears the frame flag
        queue_access(FUNC_STAT_RD, 8'h00, 8'h00);
        queue_access(FUNC_STAT_RD, 8'hFF, 8'hFF);
        // undecoded codes
        for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++) begin
            queue_access(3'(f), 8'hFF, 8'hFF);
        end
        // display without interrupt: flag set, no pulse
        write_reg(REG_IDX_W'(REG_MODE), MODE_DISPLAY);
        queue_access(FUNC_LINE, 8'h00, LAST_ROW);
        queue_access(FUNC_STAT_RD, 8'h00, 8'h00);
        // a data write between the two control bytes keeps the latch
        queue_access(FUNC_CTRL_WR, 8'h01, 8'h00);
        queue_access(FUNC_DATA_WR, 8'h55, 8'h00);
        queue_access(FUNC_CTRL_WR, 8'(1 << CTRL_NO_PF_BIT), 8'h00);

        // random: mostly well-formed bursts and frames, some noise
        while (access_backlog.size() < RANDOM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                // write burst at a random place, sometimes crossing the top
                len  = $urandom_range(1, BURST_MAX);
                base = ($urandom_range(0, 9) == 0) ? HOST_ADDR_W'(VRAM_DEPTH - 4)
                                                   : HOST_ADDR_W'($urandom);
                set_address(base, 1'($urandom));
                for (int i = 0; i < len; i++) begin
                    queue_access(FUNC_DATA_WR, 8'($urandom), 8'($urandom));
                end
                stored_base.push_back(base);
                stored_len.push_back(len);
                if (stored_base.size() > BURST_KEEP) begin
                    void'(stored_base.pop_front());
                    void'(stored_len.pop_front());
                end
            end else if (pick < 50 && stored_base.size() != 0) begin
                // read back one of the recent bursts through the read-ahead
                n = $urandom_range(0, stored_base.size() - 1);
                set_address(stored_base[n], 1'b1);
                for (int i = 0; i < stored_len[n]; i++) begin
                    queue_access(FUNC_DATA_RD, 8'($urandom), 8'($urandom));
                end
            end else if (pick < 65) begin
                // register load, mostly the mode register
                if ($urandom_range(0, 1) == 0) begin
                    val = 8'($urandom);
                    if ($urandom_range(0, 3) != 0) begin
                        val = val | MODE_DISPLAY;
                    end
                    write_reg(REG_IDX_W'(REG_MODE), val);
                end else begin
                    write_reg(REG_IDX_W'($urandom), 8'($urandom));
                end
            end else if (pick < 80) begin
                // a few scanlines, often the last one, then maybe a status poll
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    queue_access(FUNC_LINE, 8'($urandom),
                                 ($urandom_range(0, 1) == 0) ? LAST_ROW : 8'($urandom));
                end
                if ($urandom_range(0, 1) == 0) begin
                    queue_access(FUNC_STAT_RD, 8'($urandom), 8'($urandom));
                end
            end else if (pick < 90) begin
                // broken pair: a lone control byte, sometimes cut by a status read
                queue_access(FUNC_CTRL_WR, 8'($urandom), 8'($urandom));
                if ($urandom_range(0, 1) == 0) begin
                    queue_access(FUNC_STAT_RD, 8'($urandom), 8'($urandom));
                end
            end else begin
                // raw noise over every code
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    queue_access(3'($urandom), 8'($urandom), 8'($urandom));
                end
            end
        end
        item_total = access_backlog.size();

        // hold reset, then let the driver run
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait until every item is sent and every result has come back
        while (access_backlog.size() != 0 || i_s_tvalid || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (due_results.size() != 0) begin
            $error("%0d results never arrived", due_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: presents backlog items on the slave side, random gaps
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            // item taken at this edge: the port now owes its result
            if (i_s_tvalid && o_s_tready) begin
                due_results.push_back(shown_result);
                items_sent++;
            end
            // bus free for a new item, valid held otherwise
            if (!i_s_tvalid || o_s_tready) begin
                if (access_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                    next_entry    = access_backlog.pop_front();
                    i_s_tvalid   <= 1'b1;
                    i_s_tdata    <= 24'(next_entry.acc);
                    shown_result <= next_entry.res;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random backpressure, compares each result with the oldest owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            if (due_results.size() == 0) begin
                $error("result with nothing owed: tdata %h", o_m_tdata);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                if (o_m_tdata[7:0] !== want.rdata) begin
                    $error("rdata: expected %h, got %h", want.rdata, o_m_tdata[7:0]);
                    fail_count++;
                end
                if (o_m_tdata[8] !== want.irq_pulse) begin
                    $error("irq_pulse: expected %b, got %b", want.irq_pulse, o_m_tdata[8]);
                    fail_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any handshake ends the run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
